[rtl/core/tiny_language_lexer_assert.svh]
// assertion macros shared by the lexer queue and emitter modules
`ifndef TINY_LANGUAGE_LEXER_ASSERT_SVH
`define TINY_LANGUAGE_LEXER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TLL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tll_pkg.sv]
// shared types and constants of the lexer
package tll_pkg;

  localparam int KIND_W = 5;
  localparam int LINE_W = 20;
  localparam int OFS_W  = 32;
  localparam int LEN_W  = 6;
  localparam int VAL_W  = 31;

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_IF      = 5'd0,
    KIND_THEN    = 5'd1,
    KIND_ELSE    = 5'd2,
    KIND_END     = 5'd3,
    KIND_REPEAT  = 5'd4,
    KIND_UNTIL   = 5'd5,
    KIND_READ    = 5'd6,
    KIND_WRITE   = 5'd7,
    KIND_ASSIGN  = 5'd8,
    KIND_EQ      = 5'd9,
    KIND_LT      = 5'd10,
    KIND_PLUS    = 5'd11,
    KIND_MINUS   = 5'd12,
    KIND_TIMES   = 5'd13,
    KIND_OVER    = 5'd14,
    KIND_POWER   = 5'd15,
    KIND_SEMI    = 5'd16,
    KIND_LPAREN  = 5'd17,
    KIND_RPAREN  = 5'd18,
    KIND_LBRACE  = 5'd19,
    KIND_RBRACE  = 5'd20,
    KIND_ID      = 5'd21,
    KIND_NUM     = 5'd22,
    KIND_ENDFILE = 5'd23,
    KIND_ERROR   = 5'd24
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [LINE_W-1:0]  line;
    logic [OFS_W-1:0]   start;
    logic [LEN_W-1:0]   len;
    logic [VAL_W-1:0]   val;
  } tok_t;

  // tokens caused by one input beat: one or two
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } grp_t;

  typedef struct packed {
    logic push;
    grp_t grp;
  } q_wr_t;

endpackage

[rtl/core/tll_if.sv]
// byte and token channel interfaces
interface tll_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source(output valid, ch, end_of_input, input ready);
  modport sink(input valid, ch, end_of_input, output ready);
endinterface

interface tll_out_if;
  logic                       valid;
  logic                       ready;
  logic [tll_pkg::KIND_W-1:0] token_kind;
  logic [tll_pkg::LINE_W-1:0] line_number;
  logic [tll_pkg::OFS_W-1:0]  start_offset;
  logic [tll_pkg::LEN_W-1:0]  token_length;
  logic [tll_pkg::VAL_W-1:0]  number_value;
  logic                       last;

  modport source(output valid, token_kind, line_number, start_offset, token_length,
                 number_value, last, input ready);
  modport sink(input valid, token_kind, line_number, start_offset, token_length,
               number_value, last, output ready);
endinterface

[rtl/core/tll_front.sv]
// scanner front: takes one byte a beat and classifies it into tokens
module tll_front #(
  parameter int MAX_TOKEN_CHARS = 40
) (
  input  logic            clk,
  input  logic            rst_n,
  tll_in_if.sink          in_bus,
  input  logic            q_full,
  output tll_pkg::q_wr_t  q_wr
);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam int PREFIX_CHARS = 6;
  localparam int PREFIX_W     = 8 * PREFIX_CHARS;
  localparam int PROD_W       = tll_pkg::VAL_W + 4;

  localparam logic [tll_pkg::VAL_W-1:0]  NUM_MAX  = {tll_pkg::VAL_W{1'b1}};
  localparam logic [tll_pkg::LINE_W-1:0] LINE_MAX = {tll_pkg::LINE_W{1'b1}};
  localparam logic [tll_pkg::LEN_W-1:0]  LEN_LIM  = tll_pkg::LEN_W'(MAX_TOKEN_CHARS);

  localparam logic [PREFIX_W-1:0] KW_TEXT [8] = '{
    48'h0000_0000_6966, 48'h0000_7468_656E, 48'h0000_656C_7365, 48'h0000_0065_6E64,
    48'h7265_7065_6174, 48'h0075_6E74_696C, 48'h0000_7265_6164, 48'h0077_7269_7465
  };
  localparam logic [tll_pkg::LEN_W-1:0] KW_LEN [8] = '{
    6'd2, 6'd4, 6'd4, 6'd3, 6'd6, 6'd5, 6'd4, 6'd5
  };
  localparam tll_pkg::kind_t KW_CODE [8] = '{
    tll_pkg::KIND_IF, tll_pkg::KIND_THEN, tll_pkg::KIND_ELSE, tll_pkg::KIND_END,
    tll_pkg::KIND_REPEAT, tll_pkg::KIND_UNTIL, tll_pkg::KIND_READ, tll_pkg::KIND_WRITE
  };

  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_NUM     = 6'b000010,
    M_WORD    = 6'b000100,
    M_COLON   = 6'b001000,
    M_COMMENT = 6'b010000,
    M_ERROR   = 6'b100000
  } mode_t;

  function automatic tll_pkg::kind_t kw_kind(logic [PREFIX_W-1:0] prefix,
                                             logic [tll_pkg::LEN_W-1:0] len);
    tll_pkg::kind_t k;
    k = tll_pkg::KIND_ID;
    for (int i = 0; i < 8; i++) begin
      if (len == KW_LEN[i] && prefix == KW_TEXT[i]) k = KW_CODE[i];
    end
    return k;
  endfunction

  function automatic tll_pkg::tok_t mk_tok(tll_pkg::kind_t k,
                                           logic [tll_pkg::LINE_W-1:0] line,
                                           logic [tll_pkg::OFS_W-1:0] start,
                                           logic [tll_pkg::LEN_W-1:0] len,
                                           logic [tll_pkg::VAL_W-1:0] val);
    tll_pkg::tok_t t;
    t.kind  = k;
    t.line  = line;
    t.start = start;
    t.len   = len;
    t.val   = val;
    return t;
  endfunction

  mode_t                       mode_r, mode_nxt;
  logic [tll_pkg::OFS_W-1:0]   start_r, start_nxt;
  logic [tll_pkg::OFS_W-1:0]   pos_r, pos_nxt;
  logic [tll_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [PREFIX_W-1:0]         prefix_r, prefix_nxt;
  logic [tll_pkg::VAL_W-1:0]   acc_r, acc_nxt;
  logic [tll_pkg::LINE_W-1:0]  line_r, line_nxt;
  logic [tll_pkg::LINE_W-1:0]  tok_line_r, tok_line_nxt;

  logic                        fire;
  logic [7:0]                  c;
  logic                        is_digit, is_word, is_sep, is_sym;
  tll_pkg::kind_t              sym;
  logic [PROD_W-1:0]           prod;
  logic [tll_pkg::VAL_W-1:0]   acc_step;
  tll_pkg::kind_t              word_k;
  tll_pkg::tok_t               t0, t1;
  logic                        t0_v, t1_v;

  assign in_bus.ready = !q_full;
  assign fire         = in_bus.valid && in_bus.ready;
  assign c            = in_bus.ch;

  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_word  = ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
                    ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_UNDER);
  assign is_sep   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);

  always_comb begin
    is_sym = 1'b1;
    sym    = tll_pkg::KIND_EQ;
    unique case (c)
      CH_EQ:     sym = tll_pkg::KIND_EQ;
      CH_LT:     sym = tll_pkg::KIND_LT;
      CH_PLUS:   sym = tll_pkg::KIND_PLUS;
      CH_MINUS:  sym = tll_pkg::KIND_MINUS;
      CH_STAR:   sym = tll_pkg::KIND_TIMES;
      CH_SLASH:  sym = tll_pkg::KIND_OVER;
      CH_CARET:  sym = tll_pkg::KIND_POWER;
      CH_SEMI:   sym = tll_pkg::KIND_SEMI;
      CH_LPAREN: sym = tll_pkg::KIND_LPAREN;
      CH_RPAREN: sym = tll_pkg::KIND_RPAREN;
      CH_RBRACE: sym = tll_pkg::KIND_RBRACE;
      default:   is_sym = 1'b0;
    endcase
  end

  // acc * 10 + digit as two shifts and two adds, then clamp
  assign prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
                PROD_W'(c[3:0]);
  assign acc_step = (prod > PROD_W'(NUM_MAX)) ? NUM_MAX : prod[tll_pkg::VAL_W-1:0];
  assign word_k   = kw_kind(prefix_r, len_r);

  always_comb begin
    logic fresh;
    fresh        = 1'b0;
    mode_nxt     = mode_r;
    start_nxt    = start_r;
    pos_nxt      = pos_r + tll_pkg::OFS_W'(1);
    len_nxt      = len_r;
    prefix_nxt   = prefix_r;
    acc_nxt      = acc_r;
    line_nxt     = line_r;
    tok_line_nxt = tok_line_r;
    t0_v         = 1'b0;
    t1_v         = 1'b0;
    t0 = mk_tok(tll_pkg::KIND_ERROR, tok_line_r, start_r, '0, '0);
    t1 = mk_tok(tll_pkg::KIND_ENDFILE, line_r, pos_r, '0, '0);

    if (in_bus.end_of_input) begin
      // flush whatever is pending, then end of file and back to reset values
      t1_v = 1'b1;
      unique case (mode_r)
        M_NUM: begin
          t0_v = 1'b1;
          t0   = mk_tok(tll_pkg::KIND_NUM, tok_line_r, start_r, len_r, acc_r);
        end
        M_WORD: begin
          t0_v = 1'b1;
          t0   = mk_tok(word_k, tok_line_r, start_r, len_r, '0);
        end
        M_COLON, M_COMMENT: t0_v = 1'b1;
        default: t0_v = 1'b0;
      endcase
      mode_nxt     = M_IDLE;
      start_nxt    = '0;
      pos_nxt      = '0;
      len_nxt      = '0;
      prefix_nxt   = '0;
      acc_nxt      = '0;
      line_nxt     = tll_pkg::LINE_W'(1);
      tok_line_nxt = '0;
    end else begin
      unique case (mode_r)
        M_ERROR: ;
        M_COMMENT: begin
          if (c == CH_RBRACE) mode_nxt = M_IDLE;
        end
        M_COLON: begin
          t0_v = 1'b1;
          if (c == CH_EQ) begin
            t0       = mk_tok(tll_pkg::KIND_ASSIGN, tok_line_r, start_r,
                              tll_pkg::LEN_W'(2), '0);
            mode_nxt = M_IDLE;
          end else begin
            mode_nxt = M_ERROR;
          end
        end
        M_NUM: begin
          if (is_digit) begin
            if (len_r >= LEN_LIM) begin
              t0_v     = 1'b1;
              mode_nxt = M_ERROR;
            end else begin
              acc_nxt = acc_step;
              len_nxt = len_r + tll_pkg::LEN_W'(1);
            end
          end else begin
            t0_v     = 1'b1;
            t0       = mk_tok(tll_pkg::KIND_NUM, tok_line_r, start_r, len_r, acc_r);
            mode_nxt = M_IDLE;
            fresh    = 1'b1;
          end
        end
        M_WORD: begin
          if (is_word) begin
            if (len_r >= LEN_LIM) begin
              t0_v     = 1'b1;
              mode_nxt = M_ERROR;
            end else begin
              if (len_r < tll_pkg::LEN_W'(PREFIX_CHARS)) begin
                prefix_nxt = {prefix_r[PREFIX_W-9:0], c};
              end
              len_nxt = len_r + tll_pkg::LEN_W'(1);
            end
          end else begin
            t0_v     = 1'b1;
            t0       = mk_tok(word_k, tok_line_r, start_r, len_r, '0);
            mode_nxt = M_IDLE;
            fresh    = 1'b1;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
          fresh    = 1'b1;
        end
      endcase

      if (fresh) begin
        if (is_sep) begin
          mode_nxt = M_IDLE;
        end else if (is_sym) begin
          t1_v = 1'b1;
          t1   = mk_tok(sym, line_r, pos_r, tll_pkg::LEN_W'(1), '0);
        end else if (c == CH_LBRACE || c == CH_COLON || is_digit || is_word) begin
          start_nxt    = pos_r;
          tok_line_nxt = line_r;
          prefix_nxt   = '0;
          acc_nxt      = '0;
          len_nxt      = '0;
          if (c == CH_LBRACE) begin
            mode_nxt = M_COMMENT;
          end else if (c == CH_COLON) begin
            mode_nxt = M_COLON;
          end else if (is_digit) begin
            mode_nxt = M_NUM;
            acc_nxt  = tll_pkg::VAL_W'(c[3:0]);
            len_nxt  = tll_pkg::LEN_W'(1);
          end else begin
            mode_nxt   = M_WORD;
            prefix_nxt = PREFIX_W'(c);
            len_nxt    = tll_pkg::LEN_W'(1);
          end
        end else begin
          t1_v     = 1'b1;
          t1       = mk_tok(tll_pkg::KIND_ERROR, line_r, pos_r, '0, '0);
          mode_nxt = M_ERROR;
        end
      end

      if (c == CH_LF && line_r != LINE_MAX) line_nxt = line_r + tll_pkg::LINE_W'(1);
    end
  end

  // pack into one group: the earlier token leads
  always_comb begin
    q_wr.push     = fire && (t0_v || t1_v);
    q_wr.grp.two  = t0_v && t1_v;
    q_wr.grp.tok0 = t0_v ? t0 : t1;
    q_wr.grp.tok1 = t1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      start_r    <= '0;
      pos_r      <= '0;
      len_r      <= '0;
      prefix_r   <= '0;
      acc_r      <= '0;
      line_r     <= tll_pkg::LINE_W'(1);
      tok_line_r <= '0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      start_r    <= start_nxt;
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      prefix_r   <= prefix_nxt;
      acc_r      <= acc_nxt;
      line_r     <= line_nxt;
      tok_line_r <= tok_line_nxt;
    end
  end

endmodule

[rtl/core/tll_queue.sv]
// short token group queue between front and back
`include "tiny_language_lexer_assert.svh"

module tll_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  tll_pkg::q_wr_t q_wr,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tll_pkg::grp_t  rd_grp
);

  tll_pkg::grp_t                entry_r [tll_pkg::QDEPTH];
  logic [tll_pkg::PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [tll_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;

  assign full   = (cnt_r == tll_pkg::CNT_W'(tll_pkg::QDEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_grp = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_wr.push && !pop) cnt_nxt = cnt_r + tll_pkg::CNT_W'(1);
    if (!q_wr.push && pop) cnt_nxt = cnt_r - tll_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) entry_r[wr_ptr_r] <= q_wr.grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_wr.push) wr_ptr_r <= wr_ptr_r + tll_pkg::PTR_W'(1);
      if (pop)       rd_ptr_r <= rd_ptr_r + tll_pkg::PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  `TLL_ASSERT_NOW(a_q_no_overflow, q_wr.push, !full, "token queue written while full")
  `TLL_ASSERT_NOW(a_q_no_underflow, pop, !empty, "token queue read while empty")
  `TLL_ASSERT_NEXT(a_q_fill_tracks, q_wr.push && !pop, !empty, "queue lost a pushed group")

endmodule

[rtl/core/tll_back.sv]
// emitter back: hands out each queued group as one or two token beats
`include "tiny_language_lexer_assert.svh"

module tll_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  tll_pkg::grp_t q_grp,
  output logic          q_pop,
  tll_out_if.source     out_bus
);

  tll_pkg::grp_t grp_r;
  logic          valid_r;
  logic          phase_r;
  logic          beat_done;
  logic          last_beat;
  logic          load;
  tll_pkg::tok_t cur;

  assign last_beat = phase_r || !grp_r.two;
  assign beat_done = out_bus.valid && out_bus.ready;
  assign load      = !valid_r || (beat_done && last_beat);
  assign q_pop     = load && !q_empty;
  assign cur       = phase_r ? grp_r.tok1 : grp_r.tok0;

  assign out_bus.valid        = valid_r;
  assign out_bus.token_kind   = cur.kind;
  assign out_bus.line_number  = cur.line;
  assign out_bus.start_offset = cur.start;
  assign out_bus.token_length = cur.len;
  assign out_bus.number_value = cur.val;
  assign out_bus.last         = last_beat;

  always_ff @(posedge clk) begin
    if (q_pop) grp_r <= q_grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (load) begin
      valid_r <= !q_empty;
      phase_r <= 1'b0;
    end else if (beat_done) begin
      phase_r <= 1'b1;
    end
  end

  `TLL_ASSERT_NOW(a_back_second_beat, phase_r, valid_r && grp_r.two, "second beat without pair")

endmodule

[rtl/core/tiny_language_lexer.sv]
// top level of the streaming lexer
//
//   channel  dir  beat contents                                        accepted when
//   in_bus   in   ch, end_of_input                                     valid && ready
//   out_bus  out  token_kind, line_number, start_offset, token_length,  valid && ready
//                 number_value, last
//
// one byte is taken per clock unless the queue is full; scanner step is combinational
// a byte that ends a token and is itself a token gives two beats, which the output
// side hands out one at a time; the four-entry group queue soaks up the bursts
// first token beat is offered once its group is moved from queue to output register
// rst_n is synchronous, active low: scanner idle, line counter at one, queue empty
// in_bus.ready drops only while the group queue is full; out stalls hold the beat
module tiny_language_lexer #(
  parameter int MAX_TOKEN_CHARS = 40
) (
  input  logic      clk,
  input  logic      rst_n,
  tll_in_if.sink    in_bus,
  tll_out_if.source out_bus
);

  // front to queue: push strobe plus the token group of this byte
  tll_pkg::q_wr_t q_wr;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  tll_pkg::grp_t  q_grp;

  // classifier: scanner state, number accumulation, keyword match
  tll_front #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // decouples the byte side from output stalls
  tll_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_grp (q_grp)
  );

  // output register, splits pairs into single beats and marks the last one
  tll_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_grp   (q_grp),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

endmodule

[test/tb_tiny_language_lexer.sv]
// self-checking testbench for the streaming lexer: byte stimulus, token prediction, checks
module tb_tiny_language_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOKEN_LIMIT  = 40;
  localparam int ITEM_TARGET  = 1650;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 10_000_000;
  localparam int OWED_DEPTH   = 256;
  localparam int SRC_DEPTH    = 2048;

  localparam logic [7:0]                 CH_TAB   = 8'h09;
  localparam logic [7:0]                 CH_LF    = 8'h0A;
  localparam logic [7:0]                 CH_CR    = 8'h0D;
  localparam logic [7:0]                 CH_SPACE = 8'h20;
  localparam logic [tll_pkg::VAL_W-1:0]  NUM_SAT  = '1;
  localparam logic [tll_pkg::LINE_W-1:0] LINE_SAT = '1;

  // scanner modes of the predictor
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_NUM,
    SCAN_WORD,
    SCAN_COLON,
    SCAN_COMMENT,
    SCAN_ERROR
  } scan_t;

  // one expected token beat
  typedef struct packed {
    tll_pkg::tok_t tok;
    logic          last;
  } beat_t;

  logic clk;
  logic rst_n;

  tll_in_if  in_bus ();
  tll_out_if out_bus ();

  tiny_language_lexer #(.MAX_TOKEN_CHARS(TOKEN_LIMIT)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // predictor state: mirrors the scanner, one call per accepted byte beat
  // ---------------------------------------------------------------------------
  scan_t                      mode;
  logic [tll_pkg::OFS_W-1:0]  tok_start;
  logic [tll_pkg::OFS_W-1:0]  byte_pos;
  logic [tll_pkg::LEN_W-1:0]  tok_len;
  logic [47:0]                word_head;    // first six bytes of the current word
  logic [tll_pkg::VAL_W-1:0]  num_acc;
  logic [tll_pkg::LINE_W-1:0] line_cnt;
  logic [tll_pkg::LINE_W-1:0] tok_line;

  // tokens still owed by the block, oldest at the read count
  beat_t owed_ring [OWED_DEPTH];
  int    owed_wr = 0;
  int    owed_rd = 0;
  // tokens caused by the byte being predicted
  beat_t step_beats [2];
  int    step_count = 0;

  int mismatch_count = 0;
  int items_sent     = 0;

  // stimulus knobs shared with the driver and the receiver
  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;
  bit long_hold_req = 1'b0;

  // source text of the next stream
  byte unsigned src_bytes [SRC_DEPTH];
  int           src_len = 0;
  string symbol_text = "=<+-*/^;()}";

  function automatic void owe_beat(beat_t b);
    owed_ring[owed_wr % OWED_DEPTH] = b;
    owed_wr++;
  endfunction

  function automatic int owed_count();
    return owed_wr - owed_rd;
  endfunction

  function automatic beat_t take_owed();
    beat_t b;
    b = owed_ring[owed_rd % OWED_DEPTH];
    owed_rd++;
    return b;
  endfunction

  function automatic void add_src(byte unsigned c);
    if (src_len < SRC_DEPTH) begin
      src_bytes[src_len] = c;
      src_len++;
    end else begin
      $error("source text too long for the stimulus buffer");
      mismatch_count++;
    end
  endfunction

  function automatic logic [47:0] keyword_text(int k);
    case (k)
      0: return "if";
      1: return "then";
      2: return "else";
      3: return "end";
      4: return "repeat";
      5: return "until";
      6: return "read";
      default: return "write";
    endcase
  endfunction

  function automatic int keyword_len(int k);
    logic [47:0] t;
    int n;
    t = keyword_text(k);
    n = 0;
    while (t != '0) begin
      t = t >> 8;
      n++;
    end
    return n;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  // one-byte symbols; the open brace is not one, it starts a comment
  function automatic bit symbol_of(input logic [7:0] c, output tll_pkg::kind_t k);
    k = tll_pkg::KIND_ERROR;
    case (c)
      "=": k = tll_pkg::KIND_EQ;
      "<": k = tll_pkg::KIND_LT;
      "+": k = tll_pkg::KIND_PLUS;
      "-": k = tll_pkg::KIND_MINUS;
      "*": k = tll_pkg::KIND_TIMES;
      "/": k = tll_pkg::KIND_OVER;
      "^": k = tll_pkg::KIND_POWER;
      ";": k = tll_pkg::KIND_SEMI;
      "(": k = tll_pkg::KIND_LPAREN;
      ")": k = tll_pkg::KIND_RPAREN;
      "}": k = tll_pkg::KIND_RBRACE;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // keyword only on full length and case-sensitive match of the six-byte head
  function automatic tll_pkg::kind_t word_kind();
    for (int i = 0; i < 8; i++) begin
      if (int'(tok_len) == keyword_len(i) && word_head == keyword_text(i))
        return tll_pkg::kind_t'(5'(i));
    end
    return tll_pkg::KIND_ID;
  endfunction

  function automatic void restart_scanner();
    mode      = SCAN_IDLE;
    tok_start = '0;
    byte_pos  = '0;
    tok_len   = '0;
    word_head = '0;
    num_acc   = '0;
    line_cnt  = tll_pkg::LINE_W'(1);
    tok_line  = '0;
  endfunction

  function automatic void open_token(scan_t m, logic [tll_pkg::OFS_W-1:0] pos);
    mode      = m;
    tok_start = pos;
    tok_line  = line_cnt;
    tok_len   = '0;
    word_head = '0;
    num_acc   = '0;
  endfunction

  function automatic void add_digit(logic [7:0] c);
    longint unsigned v;
    v = 64'(num_acc) * 64'd10 + 64'(c - 8'd48);
    num_acc = (v > 64'(NUM_SAT)) ? NUM_SAT : v[tll_pkg::VAL_W-1:0];
    tok_len++;
  endfunction

  function automatic void add_letter(logic [7:0] c);
    if (tok_len < 6)
      word_head = {word_head[39:0], c};
    tok_len++;
  endfunction

  function automatic void note_token(tll_pkg::kind_t k, logic [tll_pkg::LINE_W-1:0] line,
                                     logic [tll_pkg::OFS_W-1:0] start,
                                     logic [tll_pkg::LEN_W-1:0] len,
                                     logic [tll_pkg::VAL_W-1:0] val);
    beat_t b;
    b.tok.kind  = k;
    b.tok.line  = line;
    b.tok.start = start;
    b.tok.len   = len;
    b.tok.val   = val;
    b.last      = 1'b0;
    step_beats[step_count] = b;
    step_count++;
  endfunction

  // works out the tokens of one accepted byte beat and queues them
  function automatic void scan_byte(logic [7:0] c, logic eoi);
    logic [tll_pkg::OFS_W-1:0] pos;
    logic                      fresh;
    tll_pkg::kind_t            sym;
    beat_t                     b;
    pos   = byte_pos;
    fresh = 1'b0;
    if (eoi) begin
      // flush what is pending, then ENDFILE, then a fresh stream
      case (mode)
        SCAN_NUM:     note_token(tll_pkg::KIND_NUM, tok_line, tok_start, tok_len, num_acc);
        SCAN_WORD:    note_token(word_kind(), tok_line, tok_start, tok_len, '0);
        SCAN_COLON,
        SCAN_COMMENT: note_token(tll_pkg::KIND_ERROR, tok_line, tok_start, '0, '0);
        default: ;
      endcase
      note_token(tll_pkg::KIND_ENDFILE, line_cnt, pos, '0, '0);
      restart_scanner();
    end else begin
      byte_pos = pos + 1;
      case (mode)
        SCAN_ERROR: ;
        SCAN_COMMENT: begin
          if (c == "}")
            mode = SCAN_IDLE;
        end
        SCAN_COLON: begin
          if (c == "=") begin
            note_token(tll_pkg::KIND_ASSIGN, tok_line, tok_start, tll_pkg::LEN_W'(2), '0);
            mode = SCAN_IDLE;
          end else begin
            note_token(tll_pkg::KIND_ERROR, tok_line, tok_start, '0, '0);
            mode = SCAN_ERROR;
          end
        end
        SCAN_NUM: begin
          if (is_digit(c)) begin
            if (tok_len >= TOKEN_LIMIT) begin
              note_token(tll_pkg::KIND_ERROR, tok_line, tok_start, '0, '0);
              mode = SCAN_ERROR;
            end else begin
              add_digit(c);
            end
          end else begin
            note_token(tll_pkg::KIND_NUM, tok_line, tok_start, tok_len, num_acc);
            mode  = SCAN_IDLE;
            fresh = 1'b1;
          end
        end
        SCAN_WORD: begin
          if (is_word_char(c)) begin
            if (tok_len >= TOKEN_LIMIT) begin
              note_token(tll_pkg::KIND_ERROR, tok_line, tok_start, '0, '0);
              mode = SCAN_ERROR;
            end else begin
              add_letter(c);
            end
          end else begin
            note_token(word_kind(), tok_line, tok_start, tok_len, '0);
            mode  = SCAN_IDLE;
            fresh = 1'b1;
          end
        end
        default: begin
          mode  = SCAN_IDLE;
          fresh = 1'b1;
        end
      endcase

      // the byte may itself start or be a token
      if (fresh) begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
          // separator only
        end else if (symbol_of(c, sym)) begin
          note_token(sym, line_cnt, pos, tll_pkg::LEN_W'(1), '0);
        end else if (c == "{") begin
          open_token(SCAN_COMMENT, pos);
        end else if (c == ":") begin
          open_token(SCAN_COLON, pos);
        end else if (is_digit(c)) begin
          open_token(SCAN_NUM, pos);
          add_digit(c);
        end else if (is_word_char(c)) begin
          open_token(SCAN_WORD, pos);
          add_letter(c);
        end else begin
          note_token(tll_pkg::KIND_ERROR, line_cnt, pos, '0, '0);
          mode = SCAN_ERROR;
        end
      end

      // line counter sees every LF that is not an end-of-input beat, in comments and after an error too
      if (c == CH_LF && line_cnt != LINE_SAT)
        line_cnt++;
    end

    for (int i = 0; i < step_count; i++) begin
      b      = step_beats[i];
      b.last = (i == step_count - 1);
      owe_beat(b);
    end
    step_count = 0;
  endfunction

  // byte beats are predicted as the block takes them
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      scan_byte(in_bus.ch, in_bus.end_of_input);
  end

  // ---------------------------------------------------------------------------
  // token checker: each accepted beat against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : token_checker
    beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (owed_count() == 0) begin
        $error("token beat with nothing expected: kind %0d, offset %0d",
               out_bus.token_kind, out_bus.start_offset);
        mismatch_count++;
      end else begin
        want = take_owed();
        check_field("token_kind", 32'(want.tok.kind), 32'(out_bus.token_kind));
        check_field("line_number", 32'(want.tok.line), 32'(out_bus.line_number));
        check_field("start_offset", want.tok.start, out_bus.start_offset);
        check_field("token_length", 32'(want.tok.len), 32'(out_bus.token_length));
        check_field("number_value", 32'(want.tok.val), 32'(out_bus.number_value));
        check_field("last", 32'(want.last), 32'(out_bus.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // idling on both sides: mostly none or short, now and then long
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // token receiver; a long hold-off is counted here when asked for
  initial begin : token_receiver
    int hold_left;
    int g;
    hold_left     = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (receiver_calm) begin
        out_bus.ready <= 1'b1;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_bus.ready <= 1'b1;
        end else begin
          out_bus.ready <= 1'b0;
          hold_left = g - 1;
        end
      end
    end
  end

  // offers one byte beat and waits for it to be taken; valid stays high across
  // back-to-back beats
  task automatic send_beat(input logic [7:0] c, input logic eoi);
    int gap;
    @(negedge clk);
    in_bus.valid        <= 1'b1;
    in_bus.ch           <= c;
    in_bus.end_of_input <= eoi;
    do
      @(posedge clk);
    while (!in_bus.ready);
    items_sent++;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // sends the collected source text, then end of input with a junk byte
  task automatic send_source();
    for (int i = 0; i < src_len; i++)
      send_beat(src_bytes[i], 1'b0);
    send_beat(8'($urandom), 1'b1);
    src_len = 0;
  endtask

  // ---------------------------------------------------------------------------
  // source text generators
  // ---------------------------------------------------------------------------
  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++)
      add_src(s[i]);
  endfunction

  function automatic void push_keyword(int k);
    logic [47:0] t;
    t = keyword_text(k);
    for (int i = keyword_len(k) - 1; i >= 0; i--)
      add_src(t[8*i +: 8]);
  endfunction

  function automatic byte unsigned word_char();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26)
      return 8'(r) + "a";
    if (r < 52)
      return 8'(r - 26) + "A";
    return "_";
  endfunction

  function automatic byte unsigned digit_char();
    return 8'($urandom_range(0, 9)) + "0";
  endfunction

  function automatic byte unsigned separator();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // anything but a closing brace, with plenty of line feeds
  function automatic byte unsigned comment_char();
    byte unsigned c;
    if ($urandom_range(0, 3) == 0)
      return CH_LF;
    do
      c = 8'($urandom_range(0, 255));
    while (c == "}");
    return c;
  endfunction

  // one well-formed lexeme or separator run
  function automatic void push_lexeme();
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      push_keyword($urandom_range(0, 7));
    end else if (pick < 27) begin
      // near misses: a trailing word character, or a capital first letter
      k = $urandom_range(0, 7);
      push_keyword(k);
      if ($urandom_range(0, 1))
        add_src(word_char());
      else
        src_bytes[src_len - keyword_len(k)] -= 8'd32;
    end else if (pick < 37) begin
      repeat ($urandom_range(1, 8)) add_src(word_char());
    end else if (pick < 50) begin
      repeat ($urandom_range(1, 11)) add_src(digit_char());
    end else if (pick < 68) begin
      k = $urandom_range(0, symbol_text.len());
      if (k == symbol_text.len())
        push_text(":=");
      else
        add_src(symbol_text[k]);
    end else if (pick < 78) begin
      add_src("{");
      repeat ($urandom_range(0, 8)) add_src(comment_char());
      add_src("}");
    end else begin
      repeat ($urandom_range(1, 3)) add_src(separator());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every symbol, assignment, a comment across a line, and the error cases
  task automatic test_directed();
    push_text("if x:=7;{");
    add_src(CH_LF);
    push_text("}(y)=<+-*/^}");
    send_source();
    // NUL cannot start a token
    add_src(8'h00);
    send_source();
    // top byte value, then a letter that must be ignored
    add_src(8'hFF);
    add_src("a");
    send_source();
    // lone colon, both on the next byte and at end of input
    push_text(":a");
    send_source();
    push_text(":");
    send_source();
    // unclosed comment
    push_text("{");
    send_source();
    // empty stream
    send_source();
  endtask

  // runs around the length limit, and the edge of number saturation
  task automatic test_long_tokens();
    int run;
    push_text("2147483647 2147483648 0");
    send_source();
    for (int k = 0; k < 8; k++) begin
      case (k % 4)
        0: run = TOKEN_LIMIT - 1;
        1: run = TOKEN_LIMIT;
        2: run = TOKEN_LIMIT + 1;
        default: run = TOKEN_LIMIT + $urandom_range(2, 6);
      endcase
      push_lexeme();
      add_src(CH_SPACE);
      repeat (run) begin
        if (k >= 4)
          add_src(word_char());
        else if (k == 1)
          add_src("9");
        else
          add_src(digit_char());
      end
      push_text(" x;");
      send_source();
    end
  endtask

  // receiver holds off for a long stretch while bytes keep coming; every
  // symbol also closes a one-letter word, so each of those beats owes two tokens
  task automatic test_output_backpressure();
    sender_calm   = 1'b1;
    long_hold_req = 1'b1;
    repeat (60) begin
      add_src(word_char());
      add_src(symbol_text[$urandom_range(0, symbol_text.len() - 1)]);
    end
    send_source();
    sender_calm = 1'b0;
  endtask

  // random programs: mostly well-formed, some with one broken spot
  task automatic test_random_programs();
    int nlex;
    int bad_at;
    while (items_sent < ITEM_TARGET) begin
      sender_calm   = ($urandom_range(0, 5) == 0);
      receiver_calm = ($urandom_range(0, 5) == 0);
      nlex   = $urandom_range(1, 40);
      bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, nlex - 1) : -1;
      for (int i = 0; i < nlex; i++) begin
        if (i == bad_at) begin
          case ($urandom_range(0, 3))
            0: add_src(8'($urandom_range(0, 255)));
            1: begin
              add_src(":");
              add_src(word_char());
            end
            2: begin
              // colon left open at end of input
              add_src(":");
              i = nlex;
            end
            default: begin
              // comment left open at end of input
              add_src("{");
              repeat ($urandom_range(0, 6)) add_src(comment_char());
              i = nlex;
            end
          endcase
        end else begin
          push_lexeme();
          if ($urandom_range(0, 1))
            add_src(separator());
        end
      end
      send_source();
    end
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.ch           = '0;
    in_bus.end_of_input = 1'b0;
    restart_scanner();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_long_tokens();
    test_output_backpressure();
    test_random_programs();

    @(negedge clk);
    in_bus.valid <= 1'b0;
    // wait for every owed token, then a little longer for strays
    while (owed_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("tiny_language_lexer test passed");
    else
      $display("tiny_language_lexer test failed");
    $finish;
  end

  // watchdog
  initial begin
    #TIMEOUT_NS;
    $display("tiny_language_lexer test failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/tll_pkg.sv
rtl/core/tll_if.sv
rtl/core/tll_front.sv
rtl/core/tll_queue.sv
rtl/core/tll_back.sv
rtl/core/tiny_language_lexer.sv
test/tb_tiny_language_lexer.sv
